// ===== rtl/tgr_pkg.sv =====
// Package for the touch gesture recognizer.
// Holds command, gesture, edge and register index codes, width constants and the sequencer state type.
// No dependencies.
package tgr_pkg;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_MOVE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  localparam logic [2:0] EDGE_NONE   = 3'd0;
  localparam logic [2:0] EDGE_LEFT   = 3'd1;
  localparam logic [2:0] EDGE_RIGHT  = 3'd2;
  localparam logic [2:0] EDGE_TOP    = 3'd3;
  localparam logic [2:0] EDGE_BOTTOM = 3'd4;

  localparam logic [2:0] GST_EDGE  = 3'd1;
  localparam logic [2:0] GST_LEFT  = 3'd2;
  localparam logic [2:0] GST_RIGHT = 3'd3;
  localparam logic [2:0] GST_UP    = 3'd4;
  localparam logic [2:0] GST_DOWN  = 3'd5;
  localparam logic [2:0] GST_HOLD  = 3'd6;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BAND   = 3'd2;
  localparam logic [2:0] REG_SPEED  = 3'd3;
  localparam logic [2:0] REG_HOLD   = 3'd4;
  localparam logic [2:0] REG_SLOP   = 3'd5;

  localparam int unsigned QuotBits  = 17;
  localparam int unsigned CoordBits = 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/touch_gesture_recognizer_unit.sv =====
// Touch gesture recognizer: top level with slot table, sequencer and a shared
// restoring divider. Depends on tgr_pkg.
// One beat at a time: the next beat is taken the cycle after the result is taken, or
// once a beat that gives no result is done. The serial divider yields one quotient
// bit per cycle.
// Reset clears the configuration to defaults, all slot valid bits, time and hold state.
module touch_gesture_recognizer_unit #(
  parameter int unsigned MAX_TOUCHES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [3:0]                    touch_id_i,
  input  logic [tgr_pkg::CoordBits-1:0] pos_x_i,
  input  logic [tgr_pkg::CoordBits-1:0] pos_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    gesture_o,
  output logic [1:0]                    edge_side_o,
  output logic [8:0]                    swipe_progress_o,
  output logic [15:0]                   swipe_speed_o,
  output logic [tgr_pkg::CoordBits-1:0] hold_x_o,
  output logic [tgr_pkg::CoordBits-1:0] hold_y_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import tgr_pkg::*;

  localparam int unsigned IdxW  = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;
  localparam int unsigned CW    = CoordBits;
  localparam int unsigned DistW = CW + 1;
  localparam int unsigned NumW  = DistW + 10;
  localparam int unsigned DivW  = 32;

  logic [11:0] width_q, height_q, band_q;
  logic [15:0] speed_lim_q, hold_time_q;
  logic [12:0] slop_q;

  logic [MAX_TOUCHES-1:0] valid_q;
  logic [CW-1:0] sx_mem [MAX_TOUCHES];
  logic [CW-1:0] sy_mem [MAX_TOUCHES];
  logic [2:0]    edge_mem [MAX_TOUCHES];
  logic [31:0]   sms_mem [MAX_TOUCHES];
  logic [CW-1:0] rd_sx_q, rd_sy_q;
  logic [2:0]    rd_edge_q;
  logic [31:0]   rd_sms_q;

  logic [31:0] now_q;
  logic [6:0]  active_q;
  logic        armed_q;
  logic [15:0] elapsed_q;
  logic [CW-1:0] hpx_q, hpy_q;

  state_e state_q, state_d;
  logic [1:0]   cmd_q;
  logic [IdxW-1:0] id_q;
  logic         id_ok_q;
  logic [CW-1:0] x_q, y_q;

  logic [DivW-1:0]  rem_q, rem_d;
  logic [DivW-1:0]  den_q, den_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [QuotBits-1:0] quo_q, quo_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             div_speed_q, div_speed_d;
  logic [47:0]      prod_q, prod_d;

  logic [2:0]  g_q, g_d;
  logic [1:0]  es_q, es_d;
  logic [8:0]  prog_q, prog_d;
  logic [15:0] spd_q, spd_d;
  logic [CW-1:0] ox_q, ox_d, oy_q, oy_d;
  logic        ovalid_q, ovalid_d;

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 12'd1080; height_q <= 12'd1920; band_q <= 12'd20;
      speed_lim_q <= 16'd500; hold_time_q <= 16'd500; slop_q <= 13'd20;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q <= cfg_data_i[11:0];
        REG_HEIGHT: height_q <= cfg_data_i[11:0];
        REG_BAND:   band_q <= cfg_data_i[11:0];
        REG_SPEED:  speed_lim_q <= cfg_data_i;
        REG_HOLD:   hold_time_q <= cfg_data_i;
        REG_SLOP:   slop_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Operand values derived from the latched beat.
  logic [CW-1:0] adx, ady, ahx, ahy;
  logic [DistW-1:0] mdist, hdist;
  logic [31:0] dur;
  logic [2:0] new_edge;
  logic [13:0] band_e, x_e, y_e;
  logic [13:0] w_e, h_e;
  assign adx = (x_q > rd_sx_q) ? x_q - rd_sx_q : rd_sx_q - x_q;
  assign ady = (y_q > rd_sy_q) ? y_q - rd_sy_q : rd_sy_q - y_q;
  assign ahx = (x_q > hpx_q) ? x_q - hpx_q : hpx_q - x_q;
  assign ahy = (y_q > hpy_q) ? y_q - hpy_q : hpy_q - y_q;
  assign mdist = DistW'(adx) + DistW'(ady);
  assign hdist = DistW'(ahx) + DistW'(ahy);
  assign dur = now_q - rd_sms_q;
  assign band_e = {2'b0, band_q};
  assign w_e = {2'b0, width_q};
  assign h_e = {2'b0, height_q};
  assign x_e = 14'(x_q);
  assign y_e = 14'(y_q);

  always_comb begin
    if ($signed(x_e) < $signed(band_e)) new_edge = EDGE_LEFT;
    else if ($signed(x_e) > $signed(w_e - band_e)) new_edge = EDGE_RIGHT;
    else if ($signed(y_e) < $signed(band_e)) new_edge = EDGE_TOP;
    else if ($signed(y_e) > $signed(h_e - band_e)) new_edge = EDGE_BOTTOM;
    else new_edge = EDGE_NONE;
  end

  logic [DivW:0] trial;
  assign trial = {rem_q, num_q[NumW-1]} - {1'b0, den_q};

  logic tick_fire, hold_fire;
  logic [15:0] elapsed_inc;
  assign elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;

  always_comb begin
    state_d = state_q;
    rem_d = rem_q; den_d = den_q; num_d = num_q; quo_d = quo_q; cnt_d = cnt_q;
    div_speed_d = div_speed_q; prod_d = prod_q;
    g_d = g_q; es_d = es_q; prog_d = prog_q; spd_d = spd_q; ox_d = ox_q; oy_d = oy_q;
    ovalid_d = ovalid_q;
    tick_fire = 1'b0;
    hold_fire = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_READ;
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        g_d = '0; es_d = '0; prog_d = '0; spd_d = '0; ox_d = '0; oy_d = '0;
        state_d = ST_IDLE;
        if (cmd_q == CMD_TICK) begin
          tick_fire = 1'b1;
          if (armed_q && elapsed_inc >= hold_time_q) begin
            hold_fire = 1'b1;
            g_d = GST_HOLD; ox_d = hpx_q; oy_d = hpy_q;
            ovalid_d = 1'b1; state_d = ST_OUT;
          end
        end else if (id_ok_q && cmd_q == CMD_MOVE && valid_q[id_q] &&
                     rd_edge_q != EDGE_NONE) begin
          g_d = GST_EDGE;
          es_d = 2'(rd_edge_q - 3'd1);
          div_speed_d = 1'b0;
          rem_d = '0; quo_d = '0; cnt_d = '0;
          if (rd_edge_q == EDGE_LEFT) begin
            num_d = NumW'(x_q) * NumW'(640);
            den_d = (width_q != 0) ? DivW'(width_q) : DivW'(1);
            state_d = ST_DIV;
          end else if (rd_edge_q == EDGE_BOTTOM && 12'(y_q) < height_q) begin
            num_d = NumW'(height_q - 12'(y_q)) * NumW'(640);
            den_d = DivW'(height_q);
            state_d = ST_DIV;
          end else begin
            ovalid_d = 1'b1; state_d = ST_OUT;
          end
        end else if (id_ok_q && cmd_q == CMD_RELEASE && valid_q[id_q] && dur != 0) begin
          prod_d = 48'(speed_lim_q) * 48'(dur);
          num_d = NumW'(mdist) * NumW'(1000);
          den_d = dur;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (48'(num_q) > prod_q) begin
          div_speed_d = 1'b1;
          rem_d = '0; quo_d = '0; cnt_d = '0;
          if (adx > ady) g_d = (x_q > rd_sx_q) ? GST_RIGHT : GST_LEFT;
          else g_d = (y_q > rd_sy_q) ? GST_DOWN : GST_UP;
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        num_d = {num_q[NumW-2:0], 1'b0};
        if (!trial[DivW]) begin
          rem_d = trial[DivW-1:0];
          quo_d = (quo_q[QuotBits-1]) ? quo_q : {quo_q[QuotBits-2:0], 1'b1};
          if (quo_q[QuotBits-1]) quo_d = '1;
        end else begin
          rem_d = {rem_q[DivW-2:0], num_q[NumW-1]};
          quo_d = (quo_q[QuotBits-1]) ? '1 : {quo_q[QuotBits-2:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(NumW - 1)) begin
          if (div_speed_q) begin
            spd_d = (quo_d > QuotBits'(16'hFFFF)) ? 16'hFFFF : quo_d[15:0];
          end else begin
            prog_d = (quo_d > QuotBits'(256)) ? 9'd256 : quo_d[8:0];
          end
          ovalid_d = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          ovalid_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovalid_q <= 1'b0;
      valid_q <= '0;
      now_q <= '0;
      active_q <= '0;
      armed_q <= 1'b0;
      elapsed_q <= '0;
      hpx_q <= '0;
      hpy_q <= '0;
      div_speed_q <= 1'b0;
      quo_q <= '0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
      div_speed_q <= div_speed_d;
      quo_q <= quo_d;
      if (tick_fire) begin
        now_q <= now_q + 32'd1;
        if (armed_q) elapsed_q <= elapsed_inc;
        if (hold_fire) armed_q <= 1'b0;
      end
      if (state_q == ST_EXEC && id_ok_q) begin
        case (cmd_q)
          CMD_PRESS: begin
            valid_q[id_q] <= 1'b1;
            if ((valid_q[id_q] ? active_q : active_q + 7'd1) == 7'd1) begin
              armed_q <= 1'b1; elapsed_q <= '0; hpx_q <= x_q; hpy_q <= y_q;
            end
            if (!valid_q[id_q]) active_q <= active_q + 7'd1;
          end
          CMD_MOVE: begin
            if (valid_q[id_q] && armed_q && 14'(hdist) > 14'(slop_q)) armed_q <= 1'b0;
          end
          CMD_RELEASE: begin
            if (valid_q[id_q]) begin
              armed_q <= 1'b0;
              valid_q[id_q] <= 1'b0;
              if (active_q != 0) active_q <= active_q - 7'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_i;
      id_q <= IdxW'(touch_id_i);
      id_ok_q <= 32'(touch_id_i) < MAX_TOUCHES;
      x_q <= pos_x_i;
      y_q <= pos_y_i;
    end
    if (state_q == ST_READ) begin
      rd_sx_q <= sx_mem[id_q];
      rd_sy_q <= sy_mem[id_q];
      rd_edge_q <= edge_mem[id_q];
      rd_sms_q <= sms_mem[id_q];
    end
    if (state_q == ST_EXEC && id_ok_q && cmd_q == CMD_PRESS) begin
      sx_mem[id_q] <= x_q;
      sy_mem[id_q] <= y_q;
      edge_mem[id_q] <= new_edge;
      sms_mem[id_q] <= now_q;
    end
    rem_q <= rem_d; den_q <= den_d; num_q <= num_d; cnt_q <= cnt_d; prod_q <= prod_d;
    g_q <= g_d; es_q <= es_d; prog_q <= prog_d; spd_q <= spd_d; ox_q <= ox_d; oy_q <= oy_d;
  end

  assign out_valid_o      = ovalid_q;
  assign gesture_o        = g_q;
  assign edge_side_o      = es_q;
  assign swipe_progress_o = prog_q;
  assign swipe_speed_o    = spd_q;
  assign hold_x_o         = ox_q;
  assign hold_y_o         = oy_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ovalid_q) else $error("ready while result pending");
  a_active_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(active_q) == $countones(valid_q)) else $error("active count mismatch");
  a_hold_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && gesture_o == GST_HOLD) |-> !armed_q) else $error("hold still armed");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |=> !$past(in_fire)) else $error("beat taken while busy");
`endif

endmodule

// ===== verif/touch_gesture_recognizer_unit_tb.sv =====
// Testbench for touch_gesture_recognizer_unit: drives press, move, release and tick beats,
// predicts each gesture in a scoreboard class and checks every result beat field by field.
// Depends on tgr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module touch_gesture_recognizer_unit_tb;
  import tgr_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [2:0]  gesture;
    logic [1:0]  side;
    logic [8:0]  progress;
    logic [15:0] speed;
    logic [11:0] hx;
    logic [11:0] hy;
  } gesture_t;

  class gesture_scoreboard;
    logic [11:0] width, height, band;
    logic [15:0] speed_limit, hold_time;
    logic [12:0] slop;
    logic        tracked [16];
    logic [11:0] start_x [16];
    logic [11:0] start_y [16];
    logic [2:0]  edge_kind [16];
    logic [31:0] start_ms [16];
    logic [31:0] clock_ms;
    int unsigned touches;
    logic        hold_on;
    logic [15:0] hold_count;
    logic [11:0] hold_px, hold_py;
    gesture_t    expected_gestures [$];
    int unsigned errors;

    function new();
      width = 1080; height = 1920; band = 20;
      speed_limit = 500; hold_time = 500; slop = 20;
      for (int i = 0; i < 16; i++) begin
        tracked[i] = 1'b0;
      end
      clock_ms = 0; touches = 0; hold_on = 1'b0; hold_count = 0;
      hold_px = 0; hold_py = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_WIDTH:  width = data[11:0];
        REG_HEIGHT: height = data[11:0];
        REG_BAND:   band = data[11:0];
        REG_SPEED:  speed_limit = data;
        REG_HOLD:   hold_time = data;
        REG_SLOP:   slop = data[12:0];
        default: ;
      endcase
    endfunction

    function logic [2:0] classify(logic [11:0] x, logic [11:0] y);
      longint b;
      b = band;
      if (longint'(x) < b) return EDGE_LEFT;
      if (longint'(x) > longint'(width) - b) return EDGE_RIGHT;
      if (longint'(y) < b) return EDGE_TOP;
      if (longint'(y) > longint'(height) - b) return EDGE_BOTTOM;
      return EDGE_NONE;
    endfunction

    function logic [8:0] progress_of(logic [2:0] e, logic [11:0] x, logic [11:0] y);
      longint p;
      longint d;
      p = 0;
      if (e == EDGE_LEFT) begin
        d = (width == 0) ? 1 : width;
        p = (longint'(x) * 640) / d;
      end else if (e == EDGE_BOTTOM && y < height) begin
        d = (height == 0) ? 1 : height;
        p = (longint'(height - y) * 640) / d;
      end
      return (p > 256) ? 9'd256 : p[8:0];
    endfunction

    function void note_input(cmd_e c, logic [3:0] id, logic [11:0] x, logic [11:0] y);
      gesture_t g;
      longint adx, ady, mdist, dur, v;
      g = '0;
      case (c)
        CMD_TICK: begin
          clock_ms = clock_ms + 1;
          if (hold_on) begin
            if (hold_count != 16'hFFFF) hold_count++;
            if (hold_count >= hold_time) begin
              hold_on = 1'b0;
              g.gesture = GST_HOLD; g.hx = hold_px; g.hy = hold_py;
              expected_gestures.push_back(g);
            end
          end
        end
        CMD_PRESS: begin
          if (!tracked[id]) begin
            tracked[id] = 1'b1;
            touches++;
          end
          start_x[id] = x; start_y[id] = y; start_ms[id] = clock_ms;
          edge_kind[id] = classify(x, y);
          if (touches == 1) begin
            hold_on = 1'b1; hold_count = 0; hold_px = x; hold_py = y;
          end
        end
        CMD_MOVE: begin
          if (tracked[id]) begin
            adx = (x > hold_px) ? x - hold_px : hold_px - x;
            ady = (y > hold_py) ? y - hold_py : hold_py - y;
            if (hold_on && adx + ady > slop) hold_on = 1'b0;
            if (edge_kind[id] != EDGE_NONE) begin
              g.gesture = GST_EDGE;
              g.side = 2'(edge_kind[id] - 3'd1);
              g.progress = progress_of(edge_kind[id], x, y);
              expected_gestures.push_back(g);
            end
          end
        end
        default: begin
          if (tracked[id]) begin
            adx = (x > start_x[id]) ? x - start_x[id] : start_x[id] - x;
            ady = (y > start_y[id]) ? y - start_y[id] : start_y[id] - y;
            mdist = adx + ady;
            dur = longint'(clock_ms - start_ms[id]);
            hold_on = 1'b0;
            tracked[id] = 1'b0;
            if (touches > 0) touches--;
            if (dur > 0 && mdist * 1000 > longint'(speed_limit) * dur) begin
              v = (mdist * 1000) / dur;
              if (adx > ady) g.gesture = (x > start_x[id]) ? GST_RIGHT : GST_LEFT;
              else g.gesture = (y > start_y[id]) ? GST_DOWN : GST_UP;
              g.speed = (v > 65535) ? 16'hFFFF : v[15:0];
              expected_gestures.push_back(g);
            end
          end
        end
      endcase
    endfunction

    function void check(gesture_t act);
      gesture_t exp_g;
      if (expected_gestures.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, act);
        errors++;
        return;
      end
      exp_g = expected_gestures.pop_front();
      if (act.gesture != exp_g.gesture) begin
        $display("%0t: gesture expected %0d actual %0d", $time, exp_g.gesture, act.gesture);
        errors++;
      end
      if (act.side != exp_g.side) begin
        $display("%0t: edge_side expected %0d actual %0d", $time, exp_g.side, act.side);
        errors++;
      end
      if (act.progress != exp_g.progress) begin
        $display("%0t: swipe_progress expected %0d actual %0d", $time, exp_g.progress,
                 act.progress);
        errors++;
      end
      if (act.speed != exp_g.speed) begin
        $display("%0t: swipe_speed expected %0d actual %0d", $time, exp_g.speed, act.speed);
        errors++;
      end
      if (act.hx != exp_g.hx || act.hy != exp_g.hy) begin
        $display("%0t: hold position expected %0d,%0d actual %0d,%0d", $time, exp_g.hx,
                 exp_g.hy, act.hx, act.hy);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid, in_ready;
  logic [1:0]  cmd;
  logic [3:0]  touch_id;
  logic [11:0] pos_x, pos_y;
  logic        out_valid, out_ready;
  logic [2:0]  gesture;
  logic [1:0]  edge_side;
  logic [8:0]  swipe_progress;
  logic [15:0] swipe_speed;
  logic [11:0] hold_x, hold_y;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  gesture_scoreboard sb;
  int unsigned cycles;
  int unsigned holdoff_req;

  touch_gesture_recognizer_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .touch_id_i(touch_id), .pos_x_i(pos_x), .pos_y_i(pos_y),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .gesture_o(gesture), .edge_side_o(edge_side), .swipe_progress_o(swipe_progress),
    .swipe_speed_o(swipe_speed), .hold_x_o(hold_x), .hold_y_o(hold_y),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: switches between always ready, light and heavy stalling, and long hold-offs.
  initial begin
    int unsigned mode, mode_left, holdoff_left;
    mode = 0; mode_left = 0; holdoff_left = 0;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready)
        sb.check('{gesture, edge_side, swipe_progress, swipe_speed, hold_x, hold_y});
      if (holdoff_req != 0) begin
        holdoff_left = holdoff_req;
        holdoff_req = 0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic send_beat(cmd_e c, logic [3:0] id, logic [11:0] x, logic [11:0] y);
    in_valid <= 1'b1;
    cmd <= c; touch_id <= id; pos_x <= x; pos_y <= y;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(c, id, x, y);
  endtask

  task automatic pause_input(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (sb.expected_gestures.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [15:0] w, logic [15:0] h, logic [15:0] b,
                              logic [15:0] s, logic [15:0] t, logic [15:0] sl);
    logic [15:0] vals [6];
    vals = '{w, h, b, s, t, sl};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      do @(posedge clk_i); while (!cfg_ready);
      sb.write_reg(3'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [11:0] near_coord(logic [11:0] c, int unsigned r);
    int v;
    v = int'(c) + $urandom_range(0, 2 * r) - int'(r);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  function automatic logic [11:0] pick_coord(logic [11:0] lim);
    case ($urandom_range(0, 3))
      0: return 12'($urandom_range(0, 40));
      1: return 12'(4095 - $urandom_range(0, 40));
      2: return near_coord(lim, 40);
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned done, burst, ticks, op;
    logic [3:0]  id;
    logic [11:0] x, y;
    done = 0; burst = $urandom_range(1, 20);
    while (done < n) begin
      op = $urandom_range(0, 99);
      if ($urandom_range(0, 4) != 0) id = 4'($urandom_range(0, 3));
      else id = 4'($urandom_range(0, 15));
      if (op >= 20 && op < 65 && $urandom_range(0, 6) != 0) begin
        for (int i = 0; i < 16; i++) begin
          if (sb.tracked[(int'(id) + i) % 16]) begin
            id = 4'((int'(id) + i) % 16);
            break;
          end
        end
      end
      if (sb.tracked[id] && $urandom_range(0, 1) == 1) begin
        x = near_coord(sb.start_x[id], $urandom_range(0, 1) ? 20 : 400);
        y = near_coord(sb.start_y[id], $urandom_range(0, 1) ? 20 : 400);
      end else begin
        x = pick_coord(sb.width);
        y = pick_coord(sb.height);
      end
      if (op < 20) begin
        send_beat(CMD_PRESS, id, x, y);
        done++;
      end else if (op < 45) begin
        send_beat(CMD_MOVE, id, x, y);
        done++;
      end else if (op < 65) begin
        send_beat(CMD_RELEASE, id, x, y);
        done++;
      end else begin
        ticks = $urandom_range(1, 8);
        repeat (ticks) send_beat(CMD_TICK, 4'($urandom_range(0, 15)),
                                 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        done += ticks;
      end
      if (burst > 0) burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 12));
      end
    end
  endtask

  initial begin
    sb = new();
    holdoff_req = 0;
    in_valid = 1'b0; cmd = CMD_TICK; touch_id = '0; pos_x = '0; pos_y = '0;
    cfg_valid = 1'b0; cfg_index = REG_WIDTH; cfg_data = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats with a short hold time.
    program_regs(1080, 1920, 20, 500, 3, 20);
    send_beat(CMD_TICK, 4'd0, 12'd0, 12'd0);
    send_beat(CMD_MOVE, 4'd5, 12'd100, 12'd100);
    send_beat(CMD_RELEASE, 4'd6, 12'd100, 12'd100);
    send_beat(CMD_PRESS, 4'd0, 12'd0, 12'd0);
    send_beat(CMD_MOVE, 4'd0, 12'd4095, 12'd4095);
    send_beat(CMD_PRESS, 4'd0, 12'd1070, 12'd500);
    repeat (3) send_beat(CMD_TICK, 4'd15, 12'd4095, 12'd4095);
    send_beat(CMD_PRESS, 4'd1, 12'd500, 12'd5);
    send_beat(CMD_MOVE, 4'd1, 12'd500, 12'd10);
    send_beat(CMD_PRESS, 4'd2, 12'd500, 12'd1915);
    send_beat(CMD_MOVE, 4'd2, 12'd500, 12'd1900);
    send_beat(CMD_TICK, 4'd0, 12'd0, 12'd0);
    send_beat(CMD_RELEASE, 4'd1, 12'd500, 12'd900);
    send_beat(CMD_RELEASE, 4'd2, 12'd100, 12'd1900);
    send_beat(CMD_RELEASE, 4'd0, 12'd4095, 12'd500);
    send_beat(CMD_RELEASE, 4'd0, 12'd0, 12'd500);
    send_beat(CMD_PRESS, 4'd3, 12'd4095, 12'd4095);
    send_beat(CMD_RELEASE, 4'd3, 12'd4095, 12'd4095);
    send_beat(CMD_PRESS, 4'd4, 12'd500, 12'd500);
    send_beat(CMD_TICK, 4'd0, 12'd0, 12'd0);
    send_beat(CMD_RELEASE, 4'd4, 12'd500, 12'd400);
    wait_all_results();

    program_regs(1080, 1920, 20, 500, 5, 20);
    random_phase(100);
    // Receiver holds off while beats keep coming, so the block backs up.
    holdoff_req = 400;
    random_phase(100);
    wait_all_results();

    program_regs(1, 1, 0, 0, 1, 0);
    random_phase(200);
    wait_all_results();

    program_regs(4095, 4095, 4095, 65535, 65535, 8190);
    random_phase(150);
    wait_all_results();

    program_regs($urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(0, 200),
                 $urandom_range(0, 65535), $urandom_range(1, 40), $urandom_range(0, 8190));
    random_phase(200);
    wait_all_results();

    program_regs(640, 480, 40, 2000, 10, 100);
    random_phase(280);
    wait_all_results();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== touch_gesture_recognizer_unit.f =====
rtl/tgr_pkg.sv
rtl/touch_gesture_recognizer_unit.sv
verif/touch_gesture_recognizer_unit_tb.sv
